// ===== rtl/core/ifp_pkg.sv =====
// Package for the IMU frame parser: sizes, codes and the parser-to-emitter
// handoff type. No dependencies.
`timescale 1ns / 1ps

package ifp_pkg;

	localparam int MAX_PAYLOAD = 40;
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int STORE_DEPTH = 12;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int VAL_MAX     = STORE_DEPTH / 2;

	// Configuration register indexes
	localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
	localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hFF;

	// Mode byte codes
	localparam logic [7:0] MODE_ACC_GYRO = 8'h01;
	localparam logic [7:0] MODE_EULER    = 8'h03;
	localparam logic [7:0] MODE_QUAT     = 8'h04;

	// Output kind codes
	localparam logic [1:0] KIND_ACC_GYRO = 2'd0;
	localparam logic [1:0] KIND_EULER    = 2'd1;
	localparam logic [1:0] KIND_QUAT     = 2'd2;

	typedef logic [15:0] word_t;

	typedef struct packed {
		logic                      valid;
		logic [1:0]                kind;
		logic [2:0]                count;
		logic [VAL_MAX-1:0][15:0]  words;
	} emit_t;

	// Number of 16-bit values a frame kind carries
	function automatic logic [2:0] values_per_kind(input logic [1:0] kind);
		case (kind)
			KIND_ACC_GYRO: values_per_kind = 3'd6;
			KIND_EULER:    values_per_kind = 3'd3;
			KIND_QUAT:     values_per_kind = 3'd4;
			default:       values_per_kind = 3'd6;
		endcase
	endfunction

endpackage

// ===== rtl/core/ifp_parser.sv =====
// Frame parser: sync/mode/length header, payload capture, sum and add checks.
// Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [7:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          emit_busy,
	output ifp_pkg::emit_t emit
);
	import ifp_pkg::*;

	localparam logic [2:0] PH_SYNC1 = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_MODE  = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_SUM   = 3'd5;
	localparam logic [2:0] PH_ADD   = 3'd6;

	logic [7:0]       sync_first_q, sync_second_q;
	logic [2:0]       phase_q;
	logic [1:0]       kind_q;
	logic [LEN_W-1:0] length_q, count_q;
	logic [7:0]       sum_q, add_q, rx_sum_q;
	logic [7:0]       store_q [STORE_DEPTH];

	logic             accept;
	logic [7:0]       sum_base, sum_n, add_base, add_n;
	logic [LEN_W:0]   count_inc;
	logic [2:0]       val_cnt;
	logic             mode_ok;
	logic [1:0]       mode_kind;

	// A finished frame cannot hand off while the emitter still drains.
	assign in_ready = !(emit_busy && phase_q == PH_ADD);
	assign accept   = in_valid && in_ready;

	// Checksum absorb; a first sync byte restarts both sums.
	assign sum_base  = (phase_q == PH_SYNC1) ? 8'd0 : sum_q;
	assign add_base  = (phase_q == PH_SYNC1) ? 8'd0 : add_q;
	assign sum_n     = sum_base + in_byte;
	assign add_n     = add_base + sum_n;
	assign count_inc = {1'b0, count_q} + {{LEN_W{1'b0}}, 1'b1};

	always_comb begin
		mode_ok   = 1'b1;
		mode_kind = KIND_ACC_GYRO;
		case (in_byte)
			MODE_ACC_GYRO: mode_kind = KIND_ACC_GYRO;
			MODE_EULER:    mode_kind = KIND_EULER;
			MODE_QUAT:     mode_kind = KIND_QUAT;
			default:       mode_ok   = 1'b0;
		endcase
	end

	assign val_cnt = values_per_kind(kind_q);

	always_comb begin
		emit.valid = accept && phase_q == PH_ADD && rx_sum_q == sum_q &&
			in_byte == add_q &&
			{2'b0, length_q} >= {{(LEN_W - 2){1'b0}}, val_cnt, 1'b0};
		emit.kind  = kind_q;
		emit.count = val_cnt;
		for (int i = 0; i < VAL_MAX; i++) begin
			emit.words[i] = {store_q[2*i+1], store_q[2*i]};
		end
	end

	// Payload store: no reset, only entries written in the current frame are read
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_DATA && count_q < LEN_W'(STORE_DEPTH)) begin
			store_q[count_q[STORE_AW-1:0]] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			phase_q       <= PH_SYNC1;
			kind_q        <= KIND_ACC_GYRO;
			length_q      <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			add_q         <= '0;
			rx_sum_q      <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_SYNC_FIRST) begin
					sync_first_q <= cfg_data;
				end else if (cfg_index == CFG_SYNC_SECOND) begin
					sync_second_q <= cfg_data;
				end
			end
			if (accept) begin
				case (phase_q)
					PH_SYNC1: begin
						if (in_byte == sync_first_q) begin
							sum_q   <= sum_n;
							add_q   <= add_n;
							phase_q <= PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						if (in_byte == sync_second_q) begin
							sum_q   <= sum_n;
							add_q   <= add_n;
							phase_q <= PH_MODE;
						end else begin
							phase_q <= PH_SYNC1;
						end
					end
					PH_MODE: begin
						if (mode_ok) begin
							kind_q  <= mode_kind;
							sum_q   <= sum_n;
							add_q   <= add_n;
							phase_q <= PH_LEN;
						end else begin
							phase_q <= PH_SYNC1;
						end
					end
					PH_LEN: begin
						if (in_byte > 8'(MAX_PAYLOAD)) begin
							phase_q <= PH_SYNC1;
						end else begin
							sum_q    <= sum_n;
							add_q    <= add_n;
							length_q <= in_byte[LEN_W-1:0];
							count_q  <= '0;
							phase_q  <= (in_byte == 8'd0) ? PH_SUM : PH_DATA;
						end
					end
					PH_DATA: begin
						sum_q   <= sum_n;
						add_q   <= add_n;
						count_q <= count_inc[LEN_W-1:0];
						if (count_inc >= {1'b0, length_q}) begin
							phase_q <= PH_SUM;
						end
					end
					PH_SUM: begin
						rx_sum_q <= in_byte;
						phase_q  <= PH_ADD;
					end
					PH_ADD: begin
						phase_q <= PH_SYNC1;
					end
					default: begin
						phase_q <= PH_SYNC1;
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/ifp_emitter.sv =====
// Result buffer: holds one checked frame's values and plays them out one beat
// at a time. Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  ifp_pkg::emit_t emit,
	output logic           busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_kind,
	output logic [2:0]     out_index,
	output logic [15:0]    out_value,
	output logic           out_last
);
	import ifp_pkg::*;

	logic              busy_q;
	logic [1:0]        kind_q;
	logic [2:0]        count_q, idx_q;
	word_t             words_q [VAL_MAX];
	logic              take;

	// Free again in the cycle the last beat leaves, so a new frame can load then
	assign busy      = busy_q && !(out_ready && out_last);
	assign out_valid = busy_q;
	assign out_kind  = kind_q;
	assign out_index = idx_q;
	assign out_value = words_q[0];
	assign out_last  = (idx_q == count_q - 3'd1);
	assign take      = busy_q && out_ready;

	// Words shift toward slot 0 as beats go out
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			kind_q  <= emit.kind;
			count_q <= emit.count;
			for (int i = 0; i < VAL_MAX; i++) begin
				words_q[i] <= emit.words[i];
			end
		end else if (take) begin
			for (int i = 0; i < VAL_MAX - 1; i++) begin
				words_q[i] <= words_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

// ===== rtl/core/imu_frame_parser.sv =====
// Top level of the IMU frame parser: stream ports, configuration port.
// Depends on ifp_pkg, ifp_parser and ifp_emitter.
`timescale 1ns / 1ps

// Takes received serial bytes, one per beat on the slave side, and hunts for
// frames: sync_first, sync_second, a mode byte (0x01 accel/gyro, 0x03 Euler,
// 0x04 quaternion), a length byte (0..40), the payload, a sum-check byte and
// an add-check byte. The sum check is the mod-256 sum of header and payload;
// the add check is the mod-256 total of the running sum after each of those
// bytes. A frame that passes both checks and is long enough for its mode puts
// out its little-endian signed 16-bit values (6, 3 or 4) as master-side
// beats, one per cycle while the master side is ready, with tlast on the
// final value. Frames that fail, are too short or declare a length above 40
// give no beats. A byte is taken every cycle; the only stall is on the
// add-check byte of a frame while the previous frame's values are still
// draining (the result buffer holds one frame and takes the next one in the
// cycle its last value leaves). A frame is at least six bytes and gives at
// most six values, so this never happens when the master side is always
// ready. The check byte's beat loads the buffer, so the first value appears
// in the cycle after it is accepted. Sync bytes are set through the
// configuration port (index 0: first sync, index 1: second sync; other
// indexes are ignored); cfg_ready is always high. Write it only while idle.
module imu_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Received bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	// Frame values
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [2:0] value_index, [18:3] value, [23:19] zero
	output logic [1:0]  m_tuser,    // [1:0] kind
	output logic        m_tlast     // last value of the frame
);
	import ifp_pkg::*;

	emit_t       emit;
	logic        emit_busy;
	logic [2:0]  value_index;
	logic [15:0] value;

	assign cfg_ready = 1'b1;

	// Header/payload/check state machine plus config registers
	ifp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.emit_busy (emit_busy),
		.emit      (emit)
	);

	// One-frame result buffer driving the master side
	ifp_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.busy      (emit_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_index (value_index),
		.out_value (value),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'd0, value, value_index};

endmodule

// ===== tb/imu_frame_parser_tb.sv =====
// Self-checking testbench for imu_frame_parser: drives received bytes and
// sync-byte writes, checks every value beat against an in-bench frame decoder.
// Depends on ifp_pkg and the imu_frame_parser RTL.
`timescale 1ns / 1ps

module imu_frame_parser_tb;
	import ifp_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;  // watchdog limit on the whole run
	localparam int DRAIN_CYCLES = 16;      // quiet time before a register write / the end
	localparam int MAX_GAP      = 40;      // cap on one sender gap
	localparam int N_DIRECTED   = 18;
	localparam logic [7:0] CFG_UNUSED = 8'hFF;  // no register here, write must be ignored

	// Decoder hunt states
	typedef enum logic [2:0] {
		HUNT_SYNC1, HUNT_SYNC2, GET_MODE, GET_LEN, GET_DATA, GET_SUM, GET_ADD
	} hunt_state_e;

	// Ways a generated frame is damaged
	typedef enum logic [2:0] {
		FLAW_NONE,    // well formed
		FLAW_SYNC2,   // second sync byte wrong, frame stops there
		FLAW_SUM,     // sum-check byte corrupted
		FLAW_ADD,     // add-check byte corrupted
		FLAW_RESYNC   // extra first sync byte up front; the frame must be lost
	} flaw_e;

	// One value beat as seen on the master side
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  index;
		logic [15:0] value;
		logic        last;
	} imu_value_t;

	// One frame of directed stimulus. Payload is either random or the word
	// repeated little-endian. Rows marked typed carry their own expectation:
	// exp_count beats of kind exp_kind, each holding word.
	typedef struct packed {
		logic [7:0]  mode;
		logic [7:0]  len;
		logic [15:0] word;
		logic        rand_fill;
		flaw_e       flaw;
		logic        typed;
		logic [2:0]  exp_count;
		logic [1:0]  exp_kind;
	} frame_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [2:0] value_index, [18:3] value, [23:19] zero
	logic [1:0]  m_tuser;          // [1:0] kind
	logic        m_tlast;

	imu_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// ---------------------------------------------------------------
	// Decoder state, mirrors the block's registers
	// ---------------------------------------------------------------
	logic [7:0]  sync1_q = SYNC_FIRST_RST;
	logic [7:0]  sync2_q = SYNC_SECOND_RST;
	hunt_state_e hunt_q  = HUNT_SYNC1;
	logic [1:0]  kind_q  = KIND_ACC_GYRO;
	logic [7:0]  len_q   = '0;
	logic [7:0]  count_q = '0;
	logic [7:0]  sum_q   = '0;
	logic [7:0]  add_q   = '0;
	logic [7:0]  rx_sum_q = '0;
	logic [7:0]  store_q [STORE_DEPTH];

	imu_value_t  expected_values [$];   // beats still owed by the block, oldest first
	imu_value_t  decoded_values [$];    // beats decoded from the byte just taken
	logic [7:0]  frame_bytes [$];       // frame under construction
	frame_row_t  directed_rows [N_DIRECTED];

	int failures         = 0;
	int cycles           = 0;
	int idle_pct         = 0;   // sender: chance per cycle of holding back
	int stall_pct        = 0;   // receiver: chance per cycle of tready low
	int bytes_sent       = 0;
	int values_predicted = 0;

	// ---------------------------------------------------------------
	// Clock, receiver side, watchdog
	// ---------------------------------------------------------------
	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("imu_frame_parser_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Frame decoder
	// ---------------------------------------------------------------
	function automatic logic [2:0] words_for_kind(input logic [1:0] kind);
		case (kind)
			KIND_EULER: return 3'd3;
			KIND_QUAT:  return 3'd4;
			default:    return 3'd6;
		endcase
	endfunction

	function automatic logic is_mode(input logic [7:0] b);
		return b == MODE_ACC_GYRO || b == MODE_EULER || b == MODE_QUAT;
	endfunction

	function automatic logic [1:0] kind_of_mode(input logic [7:0] b);
		case (b)
			MODE_EULER: return KIND_EULER;
			MODE_QUAT:  return KIND_QUAT;
			default:    return KIND_ACC_GYRO;
		endcase
	endfunction

	// Sum check and its running total (Fletcher-style)
	task automatic fold_check(input logic [7:0] b);
		sum_q = sum_q + b;
		add_q = add_q + sum_q;
	endtask

	// Advance the decoder by one byte; any frame values land in decoded_values
	task automatic decode_byte(input logic [7:0] b);
		int         i;
		logic [2:0] n;
		imu_value_t v;
		case (hunt_q)
			HUNT_SYNC1: begin
				if (b == sync1_q) begin
					sum_q = '0;
					add_q = '0;
					fold_check(b);
					hunt_q = HUNT_SYNC2;
				end
			end
			HUNT_SYNC2: begin
				// a mismatch drops back without looking at this byte as a first sync
				if (b == sync2_q) begin
					fold_check(b);
					hunt_q = GET_MODE;
				end else begin
					hunt_q = HUNT_SYNC1;
				end
			end
			GET_MODE: begin
				if (is_mode(b)) begin
					kind_q = kind_of_mode(b);
					fold_check(b);
					hunt_q = GET_LEN;
				end else begin
					hunt_q = HUNT_SYNC1;
				end
			end
			GET_LEN: begin
				if (b > MAX_PAYLOAD) begin
					hunt_q = HUNT_SYNC1;
				end else begin
					fold_check(b);
					len_q   = b;
					count_q = '0;
					hunt_q  = (b == 8'd0) ? GET_SUM : GET_DATA;
				end
			end
			GET_DATA: begin
				fold_check(b);
				// bytes past the store only feed the checks
				if (count_q < STORE_DEPTH)
					store_q[count_q] = b;
				count_q = count_q + 8'd1;
				if (count_q >= len_q)
					hunt_q = GET_SUM;
			end
			GET_SUM: begin
				rx_sum_q = b;
				hunt_q   = GET_ADD;
			end
			GET_ADD: begin
				n = words_for_kind(kind_q);
				// short frames pass the checks yet give nothing
				if (rx_sum_q == sum_q && b == add_q && len_q >= 2 * n) begin
					for (i = 0; i < n; i++) begin
						v.kind  = kind_q;
						v.index = i[2:0];
						v.value = {store_q[2 * i + 1], store_q[2 * i]};
						v.last  = (i == n - 1);
						decoded_values.push_back(v);
					end
				end
				hunt_q = HUNT_SYNC1;
			end
			default: hunt_q = HUNT_SYNC1;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------

	// One byte beat. s_tvalid stays high into the next call unless that call
	// opens a gap, so valid is never dropped and raised in one step.
	// On the last byte of a typed row the row's own expectation replaces the
	// decoded one.
	task automatic send_byte(input logic [7:0] b, input logic typed_end,
	                         input frame_row_t row);
		int         gap;
		int         i;
		imu_value_t v;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		decode_byte(b);
		if (typed_end) begin
			decoded_values.delete();
			for (i = 0; i < row.exp_count; i++) begin
				v.kind  = row.exp_kind;
				v.index = i[2:0];
				v.value = row.word;
				v.last  = (i == row.exp_count - 1);
				decoded_values.push_back(v);
			end
		end
		while (decoded_values.size() > 0) begin
			expected_values.push_back(decoded_values.pop_front());
			values_predicted++;
		end
	endtask

	// Lay out a frame for the current sync bytes. Bad mode and too-long
	// frames stop right after the byte that kills them.
	task automatic build_frame(input frame_row_t row);
		int         i;
		int         first;
		logic [7:0] sum;
		logic [7:0] add;
		frame_bytes.delete();
		first = 0;
		if (row.flaw == FLAW_RESYNC) begin
			frame_bytes.push_back(sync1_q);
			first = 1;
		end
		frame_bytes.push_back(sync1_q);
		if (row.flaw == FLAW_SYNC2) begin
			frame_bytes.push_back(sync2_q ^ 8'($urandom_range(255, 1)));
			return;
		end
		frame_bytes.push_back(sync2_q);
		frame_bytes.push_back(row.mode);
		if (!is_mode(row.mode))
			return;
		frame_bytes.push_back(row.len);
		if (row.len > MAX_PAYLOAD)
			return;
		for (i = 0; i < row.len; i++)
			frame_bytes.push_back(row.rand_fill ? 8'($urandom) :
			                      (i[0] ? row.word[15:8] : row.word[7:0]));
		sum = '0;
		add = '0;
		for (i = first; i < frame_bytes.size(); i++) begin
			sum = sum + frame_bytes[i];
			add = add + sum;
		end
		frame_bytes.push_back(sum ^ ((row.flaw == FLAW_SUM) ?
		                             8'h01 << $urandom_range(7) : 8'h00));
		frame_bytes.push_back(add ^ ((row.flaw == FLAW_ADD) ?
		                             8'h01 << $urandom_range(7) : 8'h00));
	endtask

	task automatic send_frame(input frame_row_t row);
		int i;
		build_frame(row);
		for (i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], row.typed && (i == frame_bytes.size() - 1), row);
	endtask

	// Good frames with random content mixed with short, too long, badly moded
	// and damaged ones, some of them preceded by line noise.
	task automatic random_traffic(input int min_bytes, input int min_values);
		int         bytes0;
		int         values0;
		int         need;
		int         pick;
		frame_row_t row;
		bytes0  = bytes_sent;
		values0 = values_predicted;
		while (bytes_sent - bytes0 < min_bytes || values_predicted - values0 < min_values) begin
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0, '0);
			row = '0;
			row.rand_fill = 1'b1;
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(2))
					0:       row.mode = MODE_ACC_GYRO;
					1:       row.mode = MODE_EULER;
					default: row.mode = MODE_QUAT;
				endcase
			end else begin
				row.mode = 8'($urandom);
			end
			need = 2 * words_for_kind(kind_of_mode(row.mode));
			pick = $urandom_range(99);
			if (pick < 70)
				row.len = 8'(need + $urandom_range(4));
			else if (pick < 80)
				row.len = 8'($urandom_range(MAX_PAYLOAD));
			else if (pick < 90)
				row.len = 8'($urandom_range(need - 1));
			else
				row.len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
			if ($urandom_range(99) < 76) begin
				row.flaw = FLAW_NONE;
			end else begin
				case ($urandom_range(3))
					0:       row.flaw = FLAW_SYNC2;
					1:       row.flaw = FLAW_SUM;
					2:       row.flaw = FLAW_ADD;
					default: row.flaw = FLAW_RESYNC;
				endcase
			end
			send_frame(row);
		end
	endtask

	// Stop sending, let every owed beat come out, then a quiet stretch
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_values.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Caller lowers cfg_valid after the last write of a batch
	task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (index == CFG_SYNC_FIRST)
			sync1_q = data;
		else if (index == CFG_SYNC_SECOND)
			sync2_q = data;
	endtask

	// ---------------------------------------------------------------
	// Receiver side check
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
			failures++;
		end
	endtask

	imu_value_t want_value;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$error("value beat with nothing owed: index %0d value 0x%h",
				       m_tdata[2:0], m_tdata[18:3]);
				failures++;
			end else begin
				want_value = expected_values.pop_front();
				check_field("kind", want_value.kind, m_tuser);
				check_field("value_index", want_value.index, m_tdata[2:0]);
				check_field("value", want_value.value, m_tdata[18:3]);
				check_field("last", want_value.last, m_tlast);
			end
		end
	end

	// ---------------------------------------------------------------
	// Run
	// ---------------------------------------------------------------
	initial begin
		logic [7:0] pick_sync;

		// Directed frames, all at the reset sync bytes.
		//                 mode            len     word      rand  flaw         typed cnt   kind
		directed_rows[0]  = '{MODE_ACC_GYRO, 8'd12,  16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd6, KIND_ACC_GYRO};
		directed_rows[1]  = '{MODE_EULER,    8'd6,   16'hFFFF, 1'b0, FLAW_NONE,   1'b1, 3'd3, KIND_EULER};
		directed_rows[2]  = '{MODE_EULER,    8'd6,   16'h8000, 1'b0, FLAW_NONE,   1'b1, 3'd3, KIND_EULER};
		directed_rows[3]  = '{MODE_QUAT,     8'd8,   16'h7FFF, 1'b0, FLAW_NONE,   1'b1, 3'd4, KIND_QUAT};
		// one byte short of what the mode needs: whole frame taken, nothing out
		directed_rows[4]  = '{MODE_ACC_GYRO, 8'd11,  16'h1357, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[5]  = '{MODE_EULER,    8'd5,   16'h1357, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[6]  = '{MODE_QUAT,     8'd7,   16'h1357, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		// empty payload goes straight to the sum check
		directed_rows[7]  = '{MODE_QUAT,     8'd0,   16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		// length over the limit drops the frame at the length byte
		directed_rows[8]  = '{MODE_EULER,    8'd41,  16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[9]  = '{MODE_ACC_GYRO, 8'd255, 16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		// unknown mode bytes
		directed_rows[10] = '{8'h00,         8'd12,  16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[11] = '{8'h02,         8'd12,  16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[12] = '{8'hFF,         8'd12,  16'h0000, 1'b0, FLAW_NONE,   1'b1, 3'd0, KIND_ACC_GYRO};
		// check failures and a broken second sync
		directed_rows[13] = '{MODE_EULER,    8'd6,   16'h1357, 1'b0, FLAW_SUM,    1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[14] = '{MODE_QUAT,     8'd8,   16'h1357, 1'b0, FLAW_ADD,    1'b1, 3'd0, KIND_ACC_GYRO};
		directed_rows[15] = '{MODE_EULER,    8'd6,   16'h1357, 1'b0, FLAW_SYNC2,  1'b1, 3'd0, KIND_ACC_GYRO};
		// longest payload, bytes past the store only feed the checks
		directed_rows[16] = '{MODE_EULER,    8'd40,  16'h2468, 1'b0, FLAW_NONE,   1'b1, 3'd3, KIND_EULER};
		// doubled first sync: the second one must not restart the hunt;
		// kept last since its tail may leave the hunt mid-frame
		directed_rows[17] = '{MODE_EULER,    8'd6,   16'h1234, 1'b0, FLAW_RESYNC, 1'b0, 3'd0, KIND_ACC_GYRO};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sync bytes, no idling on either side
		foreach (directed_rows[i])
			send_frame(directed_rows[i]);
		settle();

		// Sync bytes at the low/high extremes, sender mostly idle
		write_reg(CFG_SYNC_FIRST, 8'h00);
		write_reg(CFG_SYNC_SECOND, 8'hFF);
		cfg_valid <= 1'b0;
		idle_pct = 74;
		random_traffic(10, 3);
		settle();

		// Swapped extremes plus a write to a hole, receiver mostly stalled
		write_reg(CFG_SYNC_FIRST, 8'hFF);
		write_reg(CFG_SYNC_SECOND, 8'h00);
		write_reg(CFG_UNUSED, 8'h5A);
		cfg_valid <= 1'b0;
		idle_pct  = 0;
		stall_pct = 74;
		random_traffic(10, 3);
		settle();

		// Random sync bytes, often both the same; both sides idle now and then
		pick_sync = 8'($urandom);
		write_reg(CFG_SYNC_FIRST, pick_sync);
		write_reg(CFG_SYNC_SECOND, $urandom_range(1) ? pick_sync : 8'($urandom));
		cfg_valid <= 1'b0;
		idle_pct  = 31;
		stall_pct = 31;
		random_traffic(10, 3);
		settle();

		if (failures == 0)
			$display("imu_frame_parser_tb passed");
		else
			$display("imu_frame_parser_tb failed");
		$finish;
	end

endmodule

// ===== imu_frame_parser.f =====
rtl/core/ifp_pkg.sv
rtl/core/ifp_parser.sv
rtl/core/ifp_emitter.sv
rtl/core/imu_frame_parser.sv
tb/imu_frame_parser_tb.sv
